// File: design/extendible_hash_index_unit_assert.svh
// Assertion macros used by the index top-level design file
`ifndef EXTENDIBLE_HASH_INDEX_UNIT_ASSERT_SVH
`define EXTENDIBLE_HASH_INDEX_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define EHI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define EHI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ehi_pkg.sv
package ehi_pkg;

  localparam int MAX_DEPTH        = 8;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int INIT_DEPTH       = 2;

  localparam int DIR_SIZE = 1 << MAX_DEPTH;
  localparam int DIR_W    = MAX_DEPTH;
  localparam int LD_W     = $clog2(MAX_DEPTH + 1);
  localparam int LDSEL_W  = $clog2(MAX_DEPTH);
  localparam int USED_W   = MAX_DEPTH + 1;
  localparam int SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int KEY_W    = 31;
  localparam int HALF_W   = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HALF_W-1:0] page;
    logic [HALF_W-1:0] rec;
  } slot_t;

  typedef struct packed {
    logic [LD_W-1:0]             ld;
    logic [SLOTS_PER_BUCKET-1:0] vld;
    slot_t [SLOTS_PER_BUCKET-1:0] slot;
  } row_t;

  typedef struct packed {
    logic             en;
    logic [DIR_W-1:0] addr;
    logic [DIR_W-1:0] data;
  } dir_wr_t;

  typedef struct packed {
    logic             en;
    logic [DIR_W-1:0] addr;
    row_t             row;
  } bkt_wr_t;

endpackage

// File: design/ehi_req_if.sv
interface ehi_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [ehi_pkg::KEY_W-1:0] key;
  logic [ehi_pkg::HALF_W-1:0] record_page;
  logic [ehi_pkg::HALF_W-1:0] record_slot;

  modport source (output valid, cmd, key, record_page, record_slot, input ready);
  modport sink (input valid, cmd, key, record_page, record_slot, output ready);
endinterface

// File: design/ehi_rsp_if.sv
interface ehi_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [ehi_pkg::HALF_W-1:0] found_page;
  logic [ehi_pkg::HALF_W-1:0] found_slot;

  modport source (output valid, status, found_page, found_slot, input ready);
  modport sink (input valid, status, found_page, found_slot, output ready);
endinterface

// File: design/ehi_dir_mem.sv
module ehi_dir_mem (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ehi_pkg::DIR_W-1:0] rd_addr,
  input  ehi_pkg::dir_wr_t          wr,
  output logic [ehi_pkg::DIR_W-1:0] rd_data
);

  logic [ehi_pkg::DIR_W-1:0] mem [ehi_pkg::DIR_SIZE];
  logic [ehi_pkg::DIR_SIZE-1:0] written;
  logic [ehi_pkg::DIR_W-1:0] mem_q;
  logic [ehi_pkg::DIR_W-1:0] addr_q;
  logic                      written_q;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q  <= mem[rd_addr];
    addr_q <= rd_addr;
  end

  // track entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      written_q <= written[rd_addr];
    end
  end

  // unwritten entry i names bucket i mod 4
  assign rd_data = written_q ? mem_q : {{(ehi_pkg::DIR_W-2){1'b0}}, addr_q[1:0]};

endmodule

// File: design/ehi_bkt_mem.sv
module ehi_bkt_mem (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ehi_pkg::DIR_W-1:0] rd_addr,
  input  ehi_pkg::bkt_wr_t          wr,
  output ehi_pkg::row_t             rd_data
);

  ehi_pkg::row_t mem [ehi_pkg::DIR_SIZE];
  logic [ehi_pkg::DIR_SIZE-1:0] written;
  ehi_pkg::row_t mem_q;
  logic [ehi_pkg::DIR_W-1:0] addr_q;
  logic written_q;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.row;
    end
    mem_q  <= mem[rd_addr];
    addr_q <= rd_addr;
  end

  // track rows written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      written_q <= written[rd_addr];
    end
  end

  // unwritten row: empty, initial depth for the first four buckets
  always_comb begin
    rd_data = mem_q;
    if (!written_q) begin
      rd_data.vld = '0;
      rd_data.ld  = (addr_q < ehi_pkg::DIR_W'(4)) ? ehi_pkg::LD_W'(ehi_pkg::INIT_DEPTH)
                                                 : '0;
    end
  end

endmodule

// File: design/extendible_hash_index_unit.sv
// Extendible hash index: maps a 31-bit key to a record location (page, slot).
// Request channel req carries cmd (insert, search, remove), key and the
// record location; response channel rsp returns status and, for search and
// remove, the location found. Each request gives exactly one response.
// Requests are taken one at a time: the unit is ready only in its idle state.
// Search, remove and an insert into a bucket with a free slot pass through
// the directory read, bucket read and response states; the unit returns
// to idle, ready again, as the response is loaded into the output register.
// An insert into a full bucket splits it: a directory doubling sweep
// when needed (old depth), a directory redirect sweep (new depth),
// 2 row writes, then a retry of directory and bucket reads. The directory
// sweep handles one entry per cycle; a bucket that cannot split gives full.
// Reset restores global depth 2, four buckets and an empty table at once.
// A response waits in the output register while rsp is stalled; the next
// request is still taken, and its response holds until the register frees.
module extendible_hash_index_unit (
  input logic      clk,
  input logic      rst,
  ehi_req_if.sink  req,
  ehi_rsp_if.source rsp
);

  `include "extendible_hash_index_unit_assert.svh"

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIR    = 8'b0000_0010,
    S_BKT    = 8'b0000_0100,
    S_DBL    = 8'b0000_1000,
    S_REDIR  = 8'b0001_0000,
    S_WR_OLD = 8'b0010_0000,
    S_WR_NEW = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [1:0]                   cmd_q;
  logic [ehi_pkg::KEY_W-1:0]    key_q;
  logic [ehi_pkg::HALF_W-1:0]   page_q;
  logic [ehi_pkg::HALF_W-1:0]   rec_q;
  logic [ehi_pkg::LD_W-1:0]     gd;
  logic [ehi_pkg::USED_W-1:0]   used;
  logic [ehi_pkg::DIR_W-1:0]    bkt_q;
  logic [ehi_pkg::DIR_W-1:0]    nb_q;
  logic [ehi_pkg::LD_W-1:0]     ld_q;
  logic [ehi_pkg::DIR_W-1:0]    cnt;
  ehi_pkg::row_t                old_row;
  logic [1:0]                   res_status;
  logic [ehi_pkg::HALF_W-1:0]   res_page;
  logic [ehi_pkg::HALF_W-1:0]   res_slot;
  logic                         rsp_valid;

  logic [ehi_pkg::DIR_W-1:0]    dir_rd_addr;
  logic [ehi_pkg::DIR_W-1:0]    dir_rdata;
  ehi_pkg::dir_wr_t             dir_wr;
  ehi_pkg::row_t                row;
  ehi_pkg::bkt_wr_t             bkt_wr;
  logic [ehi_pkg::DIR_W-1:0]    span_m1;
  logic [ehi_pkg::DIR_W-1:0]    span_bit;
  logic                         cnt_last;
  logic [ehi_pkg::LDSEL_W-1:0]  ld_sel;
  logic [ehi_pkg::SLOTS_PER_BUCKET-1:0] moved;
  ehi_pkg::row_t                keep_row;
  ehi_pkg::row_t                new_row;
  logic                         hit;
  logic                         free;
  logic [ehi_pkg::SLOTS_PER_BUCKET-1:0] hit_oh;
  logic [ehi_pkg::SLOTS_PER_BUCKET-1:0] free_oh;
  ehi_pkg::slot_t               hit_slot;
  logic                         split_go;
  logic                         accept;

  // low gd bits of a value
  function automatic logic [ehi_pkg::DIR_W-1:0] low_bits(
    input logic [ehi_pkg::DIR_W-1:0] v,
    input logic [ehi_pkg::LD_W-1:0]  depth
  );
    logic [ehi_pkg::DIR_W-1:0] r;
    for (int k = 0; k < ehi_pkg::DIR_W; k++) begin
      r[k] = v[k] && (ehi_pkg::LD_W'(k) < depth);
    end
    return r;
  endfunction

  ehi_dir_mem u_dir (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (dir_rd_addr),
    .wr      (dir_wr),
    .rd_data (dir_rdata)
  );

  ehi_bkt_mem u_bkt (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (dir_rdata),
    .wr      (bkt_wr),
    .rd_data (row)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign span_m1   = low_bits('1, gd);
  assign span_bit  = ehi_pkg::DIR_W'(1) << gd;
  assign cnt_last  = (cnt == span_m1);
  assign ld_sel    = ld_q[ehi_pkg::LDSEL_W-1:0];

  // scan the bucket row for first match and first free slot
  always_comb begin
    hit_oh   = '0;
    free_oh  = '0;
    hit      = 1'b0;
    free     = 1'b0;
    hit_slot = row.slot[0];
    for (int s = 0; s < ehi_pkg::SLOTS_PER_BUCKET; s++) begin
      if (!hit && row.vld[s] && (row.slot[s].key == key_q)) begin
        hit       = 1'b1;
        hit_oh[s] = 1'b1;
        hit_slot  = row.slot[s];
      end
      if (!free && !row.vld[s]) begin
        free       = 1'b1;
        free_oh[s] = 1'b1;
      end
    end
  end

  assign split_go = (state == S_BKT) && (cmd_q == ehi_pkg::CMD_INSERT) && !free &&
                    (row.ld < ehi_pkg::LD_W'(ehi_pkg::MAX_DEPTH)) &&
                    (used < ehi_pkg::USED_W'(ehi_pkg::DIR_SIZE));

  // share the split bucket by key bit of the old local depth
  always_comb begin
    logic [ehi_pkg::SLOT_W-1:0] fill;
    logic [ehi_pkg::DIR_W-1:0] kbits;
    fill     = '0;
    keep_row = old_row;
    new_row  = old_row;
    new_row.vld = '0;
    for (int s = 0; s < ehi_pkg::SLOTS_PER_BUCKET; s++) begin
      kbits    = old_row.slot[s].key[ehi_pkg::DIR_W-1:0];
      moved[s] = old_row.vld[s] && kbits[ld_sel];
      if (moved[s]) begin
        new_row.slot[fill] = old_row.slot[s];
        new_row.vld[fill]  = 1'b1;
        fill = fill + ehi_pkg::SLOT_W'(1);
      end
    end
    keep_row.vld = old_row.vld & ~moved;
    keep_row.ld  = ld_q + ehi_pkg::LD_W'(1);
    new_row.ld   = ld_q + ehi_pkg::LD_W'(1);
  end

  // next state, memory addresses and writes
  always_comb begin
    state_next  = state;
    dir_rd_addr = low_bits(key_q[ehi_pkg::DIR_W-1:0], gd);
    dir_wr      = '0;
    bkt_wr      = '0;
    bkt_wr.addr = bkt_q;
    bkt_wr.row  = row;
    unique case (state)
      S_IDLE: begin
        dir_rd_addr = low_bits(req.key[ehi_pkg::DIR_W-1:0], gd);
        if (accept) begin
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        state_next = S_BKT;
      end
      S_BKT: begin
        state_next = S_RESP;
        unique case (cmd_q)
          ehi_pkg::CMD_INSERT: begin
            if (free) begin
              bkt_wr.en = 1'b1;
              bkt_wr.row.vld = row.vld | free_oh;
              for (int s = 0; s < ehi_pkg::SLOTS_PER_BUCKET; s++) begin
                if (free_oh[s]) begin
                  bkt_wr.row.slot[s] = '{key: key_q, page: page_q, rec: rec_q};
                end
              end
            end else if (split_go) begin
              dir_rd_addr = '0;
              state_next  = (row.ld >= gd) ? S_DBL : S_REDIR;
            end
          end
          ehi_pkg::CMD_REMOVE: begin
            if (hit) begin
              bkt_wr.en = 1'b1;
              bkt_wr.row.vld = row.vld & ~hit_oh;
            end
          end
          ehi_pkg::CMD_SEARCH, ehi_pkg::CMD_UNUSED: begin
          end
          default: begin
          end
        endcase
      end
      S_DBL: begin
        // copy the lower half of the directory into the upper half
        dir_wr.en   = 1'b1;
        dir_wr.addr = cnt | span_bit;
        dir_wr.data = dir_rdata;
        if (cnt_last) begin
          dir_rd_addr = '0;
          state_next  = S_REDIR;
        end else begin
          dir_rd_addr = cnt + ehi_pkg::DIR_W'(1);
        end
      end
      S_REDIR: begin
        // point the entries with the split bit set at the new bucket
        if ((dir_rdata == bkt_q) && cnt[ld_sel]) begin
          dir_wr.en   = 1'b1;
          dir_wr.addr = cnt;
          dir_wr.data = nb_q;
        end
        if (cnt_last) begin
          state_next = S_WR_OLD;
        end else begin
          dir_rd_addr = cnt + ehi_pkg::DIR_W'(1);
        end
      end
      S_WR_OLD: begin
        bkt_wr.en   = 1'b1;
        bkt_wr.addr = bkt_q;
        bkt_wr.row  = keep_row;
        state_next  = S_WR_NEW;
      end
      S_WR_NEW: begin
        // retry the insert: directory read goes out now
        bkt_wr.en   = 1'b1;
        bkt_wr.addr = nb_q;
        bkt_wr.row  = new_row;
        state_next  = S_DIR;
      end
      S_RESP: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gd        <= ehi_pkg::LD_W'(ehi_pkg::INIT_DEPTH);
      used      <= ehi_pkg::USED_W'(4);
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (split_go) begin
        used <= used + ehi_pkg::USED_W'(1);
        cnt  <= '0;
      end else if ((state == S_DBL) || (state == S_REDIR)) begin
        cnt <= cnt_last ? '0 : cnt + ehi_pkg::DIR_W'(1);
      end
      if ((state == S_DBL) && cnt_last) begin
        gd <= gd + ehi_pkg::LD_W'(1);
      end
      if ((state == S_RESP) && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= req.cmd;
      key_q  <= req.key;
      page_q <= req.record_page;
      rec_q  <= req.record_slot;
    end
    if (state == S_DIR) begin
      bkt_q <= dir_rdata;
    end
    if (split_go) begin
      old_row <= row;
      ld_q    <= row.ld;
      nb_q    <= used[ehi_pkg::DIR_W-1:0];
    end
    if (state == S_BKT) begin
      unique case (cmd_q)
        ehi_pkg::CMD_INSERT: begin
          res_status <= (free || split_go) ? ehi_pkg::ST_DONE : ehi_pkg::ST_FULL;
          res_page   <= '0;
          res_slot   <= '0;
        end
        ehi_pkg::CMD_SEARCH, ehi_pkg::CMD_REMOVE: begin
          res_status <= hit ? ehi_pkg::ST_DONE : ehi_pkg::ST_NOT_FOUND;
          res_page   <= hit ? hit_slot.page : '0;
          res_slot   <= hit ? hit_slot.rec : '0;
        end
        ehi_pkg::CMD_UNUSED: begin
          res_status <= ehi_pkg::ST_NOT_FOUND;
          res_page   <= '0;
          res_slot   <= '0;
        end
        default: begin
          res_status <= ehi_pkg::ST_NOT_FOUND;
          res_page   <= '0;
          res_slot   <= '0;
        end
      endcase
    end
    if ((state == S_RESP) && (!rsp_valid || rsp.ready)) begin
      rsp.status     <= res_status;
      rsp.found_page <= res_page;
      rsp.found_slot <= res_slot;
    end
  end

  assign rsp.valid = rsp_valid;

  `EHI_ASSERT_NXT(a_accept_reads_dir, accept, state == S_DIR, "accepted request did not start")
  `EHI_ASSERT_NXT(a_double_bumps_depth, (state == S_DBL) && cnt_last, gd == $past(gd) + ehi_pkg::LD_W'(1), "doubling did not raise global depth")
  `EHI_ASSERT_NXT(a_split_takes_bucket, split_go, used == $past(used) + ehi_pkg::USED_W'(1), "split did not allocate a bucket")
  `EHI_ASSERT_IMP(a_dir_write_in_sweep, dir_wr.en, (state == S_DBL) || (state == S_REDIR), "directory written outside a sweep")

endmodule

// File: dv/extendible_hash_index_unit_tb.sv
`timescale 1ns / 1ps

module extendible_hash_index_unit_tb;

  localparam int ENTRY_COUNT = ehi_pkg::DIR_SIZE * ehi_pkg::SLOTS_PER_BUCKET;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    ehi_pkg::cmd_t              cmd;
    logic [ehi_pkg::KEY_W-1:0]  key;
    logic [ehi_pkg::HALF_W-1:0] page;
    logic [ehi_pkg::HALF_W-1:0] rec;
    bit                         drain;
  } lookup_req_t;

  typedef struct {
    ehi_pkg::status_t           status;
    logic [ehi_pkg::HALF_W-1:0] page;
    logic [ehi_pkg::HALF_W-1:0] rec;
  } lookup_rsp_t;

  logic clk;
  logic rst;

  ehi_req_if req ();
  ehi_rsp_if rsp ();

  extendible_hash_index_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Shadow copy of the index
  int unsigned                gdepth;
  int unsigned                dir_map [ehi_pkg::DIR_SIZE];
  int unsigned                bkt_depth [ehi_pkg::DIR_SIZE];
  int unsigned                bkt_used;
  bit                         ent_vld [ENTRY_COUNT];
  logic [ehi_pkg::KEY_W-1:0]  ent_key [ENTRY_COUNT];
  logic [ehi_pkg::HALF_W-1:0] ent_page [ENTRY_COUNT];
  logic [ehi_pkg::HALF_W-1:0] ent_rec [ENTRY_COUNT];

  lookup_req_t               pending_reqs [$];
  lookup_rsp_t               expected_rsps [$];
  logic [ehi_pkg::KEY_W-1:0] key_pool [$];
  lookup_req_t               cur_req;
  int                        errors;
  bit                        quiet;
  int                        send_gap;
  int                        recv_gap;
  int                        hold_left;
  bit                        hold_done;
  int                        rsp_count;
  int                        idle_cycles;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic int unsigned bucket_for(logic [ehi_pkg::KEY_W-1:0] key);
    int unsigned idx;
    idx = key & ((1 << gdepth) - 1) & (ehi_pkg::DIR_SIZE - 1);
    return dir_map[idx];
  endfunction

  function automatic bit split_bucket(int unsigned b);
    int unsigned ld, nb, span, fill, e, d;
    ld = bkt_depth[b];
    if (ld >= ehi_pkg::MAX_DEPTH || bkt_used >= ehi_pkg::DIR_SIZE) return 1'b0;
    // double the directory when the bucket is at global depth
    if (ld >= gdepth) begin
      span = 1 << gdepth;
      for (int i = 0; i < span; i++) dir_map[i + span] = dir_map[i];
      gdepth++;
    end
    nb = bkt_used;
    bkt_used++;
    bkt_depth[b] = ld + 1;
    bkt_depth[nb] = ld + 1;
    span = 1 << gdepth;
    for (int i = 0; i < span; i++)
      if (dir_map[i] == b && ((i >> ld) & 1)) dir_map[i] = nb;
    // move entries with the new bit set
    fill = 0;
    for (int s = 0; s < ehi_pkg::SLOTS_PER_BUCKET; s++) begin
      e = b * ehi_pkg::SLOTS_PER_BUCKET + s;
      if (ent_vld[e] && ent_key[e][ld]) begin
        d = nb * ehi_pkg::SLOTS_PER_BUCKET + fill;
        fill++;
        ent_vld[d] = 1'b1;
        ent_key[d] = ent_key[e];
        ent_page[d] = ent_page[e];
        ent_rec[d] = ent_rec[e];
        ent_vld[e] = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic ehi_pkg::status_t insert_entry(lookup_req_t r);
    int unsigned b, e;
    forever begin
      b = bucket_for(r.key);
      for (int s = 0; s < ehi_pkg::SLOTS_PER_BUCKET; s++) begin
        e = b * ehi_pkg::SLOTS_PER_BUCKET + s;
        if (!ent_vld[e]) begin
          ent_vld[e] = 1'b1;
          ent_key[e] = r.key;
          ent_page[e] = r.page;
          ent_rec[e] = r.rec;
          return ehi_pkg::ST_DONE;
        end
      end
      if (!split_bucket(b)) return ehi_pkg::ST_FULL;
    end
  endfunction

  function automatic lookup_rsp_t lookup_result(lookup_req_t r);
    lookup_rsp_t o;
    int unsigned b, e;
    o.status = ehi_pkg::ST_NOT_FOUND;
    o.page = '0;
    o.rec = '0;
    if (r.cmd == ehi_pkg::CMD_INSERT) begin
      o.status = insert_entry(r);
    end else if (r.cmd == ehi_pkg::CMD_SEARCH || r.cmd == ehi_pkg::CMD_REMOVE) begin
      b = bucket_for(r.key);
      for (int s = 0; s < ehi_pkg::SLOTS_PER_BUCKET; s++) begin
        e = b * ehi_pkg::SLOTS_PER_BUCKET + s;
        if (o.status == ehi_pkg::ST_NOT_FOUND && ent_vld[e] && ent_key[e] == r.key) begin
          o.status = ehi_pkg::ST_DONE;
          o.page = ent_page[e];
          o.rec = ent_rec[e];
          if (r.cmd == ehi_pkg::CMD_REMOVE) ent_vld[e] = 1'b0;
        end
      end
    end
    return o;
  endfunction

  task automatic add_req(ehi_pkg::cmd_t c, logic [ehi_pkg::KEY_W-1:0] k,
                         logic [ehi_pkg::HALF_W-1:0] p, logic [ehi_pkg::HALF_W-1:0] s,
                         bit drain);
    lookup_req_t r;
    r.cmd = c;
    r.key = k;
    r.page = p;
    r.rec = s;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [ehi_pkg::KEY_W-1:0] pick_key();
    int unsigned sel;
    logic [ehi_pkg::KEY_W-1:0] k;
    sel = $urandom_range(0, 9);
    k = ehi_pkg::KEY_W'($urandom);
    if (sel < 4 && key_pool.size() > 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else if (sel < 7) k[7:0] = 8'($urandom_range(0, 31));
    return k;
  endfunction

  // Driver: present one request at a time from the pending queue
  always @(posedge clk) begin
    bit nv;
    if (rst) begin
      req.valid <= 1'b0;
      req.cmd <= ehi_pkg::CMD_INSERT;
      req.key <= '0;
      req.record_page <= '0;
      req.record_slot <= '0;
      send_gap <= 0;
    end else begin
      nv = req.valid;
      if (req.valid && req.ready) begin
        expected_rsps.push_back(lookup_result(cur_req));
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          if (pending_reqs[0].drain && expected_rsps.size() > 0) begin
            // hold until every response is back
          end else if (!quiet && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(1, 19);
          end else begin
            cur_req = pending_reqs.pop_front();
            nv = 1'b1;
            req.cmd <= cur_req.cmd;
            req.key <= cur_req.key;
            req.record_page <= cur_req.page;
            req.record_slot <= cur_req.rec;
          end
        end
      end
      req.valid <= nv;
    end
  end

  // Monitor: random stalls, one long hold-off, field-by-field checks
  always @(posedge clk) begin
    lookup_rsp_t x;
    bit nr;
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      rsp_count <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp_count <= rsp_count + 1;
        if (expected_rsps.size() == 0) begin
          $display("%0t unexpected response status %0d page %h slot %h", $realtime,
                   rsp.status, rsp.found_page, rsp.found_slot);
          errors++;
        end else begin
          x = expected_rsps.pop_front();
          if (rsp.status !== x.status) begin
            $display("%0t status expected %0d actual %0d", $realtime, x.status, rsp.status);
            errors++;
          end
          if (rsp.found_page !== x.page) begin
            $display("%0t found_page expected %h actual %h", $realtime, x.page,
                     rsp.found_page);
            errors++;
          end
          if (rsp.found_slot !== x.rec) begin
            $display("%0t found_slot expected %h actual %h", $realtime, x.rec,
                     rsp.found_slot);
            errors++;
          end
        end
      end
      nr = 1'b1;
      if (!hold_done && rsp_count == 600) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        nr = 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        nr = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 18);
        nr = 1'b0;
      end
      rsp.ready <= nr;
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ehi_pkg::cmd_t c;
    logic [ehi_pkg::KEY_W-1:0] k;
    int unsigned sel;
    rst = 1'b1;
    errors = 0;
    quiet = 1'b0;
    idle_cycles = 0;
    gdepth = ehi_pkg::INIT_DEPTH;
    for (int i = 0; i < ehi_pkg::DIR_SIZE; i++) begin
      dir_map[i] = i % 4;
      bkt_depth[i] = (i < 4) ? ehi_pkg::INIT_DEPTH : 0;
    end
    bkt_used = 4;
    for (int i = 0; i < ENTRY_COUNT; i++) ent_vld[i] = 1'b0;

    // Directed: field extremes, every command, duplicates, split, full bucket at maximum depth
    add_req(ehi_pkg::CMD_INSERT, '0, 16'h0000, 16'hffff, 1'b0);
    add_req(ehi_pkg::CMD_INSERT, 31'h7fffffff, 16'hffff, 16'h0000, 1'b0);
    add_req(ehi_pkg::CMD_SEARCH, '0, 16'h1234, 16'h5678, 1'b0);
    add_req(ehi_pkg::CMD_SEARCH, 31'h7fffffff, '0, '0, 1'b0);
    add_req(ehi_pkg::CMD_REMOVE, '0, '0, '0, 1'b0);
    add_req(ehi_pkg::CMD_SEARCH, '0, '0, '0, 1'b0);
    add_req(ehi_pkg::CMD_REMOVE, 31'h1234567, '0, '0, 1'b0);
    add_req(ehi_pkg::CMD_UNUSED, 31'h7fffffff, 16'hffff, 16'hffff, 1'b0);
    add_req(ehi_pkg::CMD_INSERT, 31'h55, 16'h0001, 16'h0001, 1'b0);
    add_req(ehi_pkg::CMD_INSERT, 31'h55, 16'h0002, 16'h0002, 1'b0);
    add_req(ehi_pkg::CMD_REMOVE, 31'h55, '0, '0, 1'b0);
    add_req(ehi_pkg::CMD_SEARCH, 31'h55, '0, '0, 1'b0);
    for (int i = 0; i < 6; i++)
      add_req(ehi_pkg::CMD_INSERT, 31'(i * 4 + 8), 16'(i), 16'(i + 100), 1'b0);
    for (int i = 0; i < 6; i++)
      add_req(ehi_pkg::CMD_INSERT, 31'(i * 256 + 1), 16'(i + 200), 16'(i + 300), 1'b0);
    add_req(ehi_pkg::CMD_SEARCH, 31'(2 * 256 + 1), '0, '0, 1'b0);

    // Random: insert-heavy, keys biased toward earlier keys and crowded low bits
    for (int n = 0; n < 1300; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 10) c = ehi_pkg::CMD_INSERT;
      else if (sel < 15) c = ehi_pkg::CMD_SEARCH;
      else if (sel < 19) c = ehi_pkg::CMD_REMOVE;
      else c = ehi_pkg::CMD_UNUSED;
      k = pick_key();
      if (c == ehi_pkg::CMD_INSERT && key_pool.size() < 512) key_pool.push_back(k);
      add_req(c, k, 16'($urandom), 16'($urandom), n == 0 || n == 700);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 150) @(posedge clk);
    quiet = 1'b1;
    while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/ehi_pkg.sv
design/ehi_req_if.sv
design/ehi_rsp_if.sv
design/ehi_dir_mem.sv
design/ehi_bkt_mem.sv
design/extendible_hash_index_unit.sv
dv/extendible_hash_index_unit_tb.sv
